>>> src/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/klt_pkg.sv
package klt_pkg;

	localparam int TABLE_DEPTH_DEF = 8;
	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

	localparam logic KIND_HEARTBEAT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] ST_CHECKING = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_LOST = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [63:0] peer_key;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [1:0] peer_state;
		logic       dropped;
	} out_t;

	typedef struct packed {
		logic        key_we;
		logic        ts_we;
		logic [63:0] key;
		logic [31:0] ts;
	} mem_wr_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] ts;
	} mem_rd_t;

endpackage

>>> src/keyed_liveness_table_top.sv
// Keyed liveness table. Keeps up to TABLE_DEPTH peer keys, filled in order of arrival, each
// with the time of its last heartbeat, in a synchronous memory. A heartbeat beat refreshes or
// appends its key and answers ok, or answers dropped when the key is zero or is new to a full
// table; a query beat answers checking for an unknown key, otherwise ok or lost by comparing the
// wrapping age now_ms minus last contact against timeout_ms. One beat is worked on at a time.
// The key lookup reads the memory one entry per cycle through its single read port, in entry
// order, and compares each registered read word with the key, stopping at the first match or
// after the last stored entry. The result is then loaded into the output register, together with
// the write-back of the key and time, once the previous result has been taken; while it still
// waits, the write-back is held back. The block returns to idle as the result is loaded.
`include "assert_macros.svh"

module keyed_liveness_table_top #(
	parameter int TABLE_DEPTH = klt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  klt_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output klt_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);

	logic [31:0]      timeout_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	klt_pkg::mem_rd_t rd_data;
	logic [IDX_W-1:0] wr_addr;
	klt_pkg::mem_wr_t wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= klt_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	klt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.timeout_ms(timeout_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_addr(wr_addr),
		.wr(wr)
	);

	klt_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_addr(wr_addr),
		.wr(wr)
	);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_SAME(a_append_writes_both, clk, arst_n, wr.key_we, wr.ts_we)
	`ASSERT_NEXT(a_write_with_result, clk, arst_n, wr.ts_we, out_valid && in_ready)
	`ASSERT_SAME(a_no_read_on_write, clk, arst_n, wr.ts_we, !rd_en)

endmodule

>>> src/klt_mem.sv
module klt_mem #(
	parameter int TABLE_DEPTH = klt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output klt_pkg::mem_rd_t  rd_data,
	input  logic [IDX_W-1:0]  wr_addr,
	input  klt_pkg::mem_wr_t  wr
);

	logic [63:0] key_mem [TABLE_DEPTH];
	logic [31:0] ts_mem [TABLE_DEPTH];
	klt_pkg::mem_rd_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= wr.key;
		end
		if (wr.ts_we) begin
			ts_mem[wr_addr] <= wr.ts;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.key <= key_mem[rd_addr];
			rd_q.ts <= ts_mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> src/klt_ctrl.sv
module klt_ctrl #(
	parameter int TABLE_DEPTH = klt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  klt_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output klt_pkg::out_t     out_data,
	input  logic [31:0]       timeout_ms,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	input  klt_pkg::mem_rd_t  rd_data,
	output logic [IDX_W-1:0]  wr_addr,
	output klt_pkg::mem_wr_t  wr
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD = 2'd2;

	logic [1:0]       state_q;
	klt_pkg::in_t     item_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [31:0]      hit_ts_q;
	logic             out_valid_q;
	klt_pkg::out_t    out_q;

	logic             hit_now;
	logic             miss_now;
	logic             can_load;
	logic             table_full;
	logic [31:0]      elapsed;
	klt_pkg::out_t    result;
	logic             append;

	assign in_ready = (state_q == S_IDLE);
	assign hit_now = cmp_vld_s1 && (rd_data.key == item_q.peer_key);
	assign miss_now = !cmp_vld_s1 && (rd_idx_q == count_q);
	assign rd_en = (state_q == S_SCAN) && !hit_now && (rd_idx_q < count_q);
	assign rd_addr = rd_idx_q[IDX_W-1:0];
	assign can_load = !out_valid_q || out_ready;
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign elapsed = item_q.now_ms - hit_ts_q;

	always_comb begin
		result.peer_state = klt_pkg::ST_CHECKING;
		result.dropped = 1'b0;
		append = 1'b0;
		wr.key_we = 1'b0;
		wr.ts_we = 1'b0;
		wr.key = item_q.peer_key;
		wr.ts = item_q.now_ms;
		if (item_q.kind == klt_pkg::KIND_HEARTBEAT) begin
			if (item_q.peer_key == 64'd0) begin
				result.dropped = 1'b1;
			end else if (hit_q) begin
				result.peer_state = klt_pkg::ST_OK;
				wr.ts_we = 1'b1;
			end else if (!table_full) begin
				result.peer_state = klt_pkg::ST_OK;
				append = 1'b1;
				wr.key_we = 1'b1;
				wr.ts_we = 1'b1;
			end else begin
				result.dropped = 1'b1;
			end
		end else if (hit_q) begin
			result.peer_state = (elapsed < timeout_ms) ? klt_pkg::ST_OK : klt_pkg::ST_LOST;
		end
		if (!((state_q == S_UPD) && can_load)) begin
			wr.key_we = 1'b0;
			wr.ts_we = 1'b0;
			append = 1'b0;
		end
	end

	assign wr_addr = hit_q ? hit_idx_q : count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_UPD) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						cmp_vld_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (hit_now) begin
						hit_q <= 1'b1;
						state_q <= S_UPD;
					end else if (miss_now) begin
						hit_q <= 1'b0;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (can_load) begin
						if (append) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if ((state_q == S_SCAN) && hit_now) begin
			hit_idx_q <= cmp_idx_s1;
			hit_ts_q <= rd_data.ts;
		end
		if ((state_q == S_UPD) && can_load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
